// ----- rtl/jac_pkg.sv -----
// Shared constants for the radar measurement Jacobian pipeline.
package jac_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int R2_W          = 64;
    localparam int R3_W          = 96;
    localparam int SQRT_STAGES   = 32;
    localparam int QUO_W         = 32;
    localparam int DIV_STAGES    = QUO_W + 1;

endpackage

// ----- rtl/jac_sqrt.sv -----
// Pipelined floor square root of a 64-bit value, one result bit per stage.
module jac_sqrt
    import jac_pkg::*;
(
    input  logic                 aclk,
    input  logic                 en,
    input  logic [R2_W-1:0]      n,
    output logic [WORD_W-1:0]    root
);

    logic [R2_W-1:0] rn_reg [0:SQRT_STAGES];
    logic [R2_W-1:0] rr_reg [0:SQRT_STAGES];

    always_comb begin
        rn_reg[0] = n;
        rr_reg[0] = '0;
    end

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        localparam logic [R2_W-1:0] BIT = R2_W'(1) << (R2_W - 2 - 2 * k);
        logic [R2_W-1:0] trial;
        logic [R2_W-1:0] rn_next;
        logic [R2_W-1:0] rr_next;

        always_comb begin
            trial = rr_reg[k] + BIT;
            if (rn_reg[k] >= trial) begin
                rn_next = rn_reg[k] - trial;
                rr_next = (rr_reg[k] >> 1) + BIT;
            end else begin
                rn_next = rn_reg[k];
                rr_next = rr_reg[k] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rn_reg[k+1] <= rn_next;
                rr_reg[k+1] <= rr_next;
            end
        end
    end

    assign root = rr_reg[SQRT_STAGES][WORD_W-1:0];

endmodule

// ----- rtl/jac_div.sv -----
// Pipelined restoring divider giving a 32-bit quotient and an overflow flag.
module jac_div
    import jac_pkg::*;
#(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32
)
(
    input  logic               aclk,
    input  logic               en,
    input  logic [NUM_W-1:0]   num,
    input  logic [DEN_W-1:0]   den,
    output logic [QUO_W-1:0]   quo,
    output logic               ovf
);

    localparam int HI_W = NUM_W - QUO_W;
    localparam int CW   = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [DEN_W-1:0] rem_reg [0:QUO_W];
    logic [DEN_W-1:0] den_reg [0:QUO_W];
    logic [QUO_W-1:0] nlo_reg [0:QUO_W];
    logic [QUO_W-1:0] q_reg   [0:QUO_W];
    logic             ovf_reg [0:QUO_W];

    logic [CW-1:0]    hi_ext;
    logic [CW-1:0]    den_ext;
    logic [DEN_W-1:0] rem_init;

    assign hi_ext  = CW'(num[NUM_W-1:QUO_W]);
    assign den_ext = CW'(den);
    assign rem_init = DEN_W'(hi_ext);

    // quotient of 2^32 or more is flagged up front; below that the remainder fits
    always_ff @(posedge aclk) begin
        if (en) begin
            ovf_reg[0] <= hi_ext >= den_ext;
            rem_reg[0] <= rem_init;
            den_reg[0] <= den;
            nlo_reg[0] <= num[QUO_W-1:0];
            q_reg[0]   <= '0;
        end
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [DEN_W:0]   t;
        logic [DEN_W:0]   diff;
        logic             take;

        always_comb begin
            t    = {rem_reg[k], nlo_reg[k][QUO_W-1-k]};
            diff = t - {1'b0, den_reg[k]};
            take = t >= {1'b0, den_reg[k]};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= take ? diff[DEN_W-1:0] : t[DEN_W-1:0];
                q_reg[k+1]   <= {q_reg[k][QUO_W-2:0], take};
                den_reg[k+1] <= den_reg[k];
                nlo_reg[k+1] <= nlo_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    assign quo = q_reg[QUO_W];
    assign ovf = ovf_reg[QUO_W];

endmodule

// ----- rtl/radar_measurement_jacobian.sv -----
// Radar measurement Jacobian: top level pipeline from tracked state to partials.
//
// Takes one state item (px, py, vx, vy, signed fixed point) per cycle and
// returns the six distinct radar Jacobian entries for each accepted item.
// Throughput is one item per clock; the latency is set by the 32-stage square
// root and the 33-stage dividers. The whole pipeline holds while a result
// waits on m_tready. Zero range gives all-zero partials with zero_range set;
// clamped results set saturated.
module radar_measurement_jacobian
    import jac_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // pos_x, pos_y, vel_x, vel_y
    output logic         m_tvalid,
    input  logic         m_tready,
    // d_range_dpx, d_range_dpy, d_bearing_dpx, d_bearing_dpy, d_rate_dpx, d_rate_dpy
    output logic [191:0] m_tdata,
    output logic [1:0]   m_tuser    // zero_range, saturated
);

    localparam int VLEN  = 2 + SQRT_STAGES + 2 + DIV_STAGES;
    localparam int NW_RG = WORD_W + FRAC_BITS;
    localparam int NW_BR = WORD_W + 2 * FRAC_BITS;
    localparam int NW_RT = R3_W + FRAC_BITS;

    typedef struct packed {
        logic [WORD_W-1:0] pm;
        logic [WORD_W-1:0] qm;
        logic              pn;
        logic              qn;
        logic [R2_W-1:0]   r2;
        logic [R2_W-1:0]   cm;
        logic              cn;
        logic              zero;
    } side_t;

    typedef struct packed {
        logic [5:0] neg;
        logic       zero;
    } dside_t;

    logic en;
    logic [VLEN-1:0] vld_reg;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    function automatic logic [WORD_W:0] mag(input logic [WORD_W-1:0] v);
        mag = {v[WORD_W-1], v[WORD_W-1] ? (~v + WORD_W'(1)) : v};
    endfunction

    // sat flag on top, saturated word below
    function automatic logic [WORD_W:0] clamp(input logic [QUO_W-1:0] q, input logic ov,
                                              input logic neg);
        logic [WORD_W:0] res;
        res = '0;
        if (ov) begin
            res = {1'b1, neg ? 32'h8000_0000 : 32'h7FFF_FFFF};
        end else if (q == '0) begin
            res = '0;
        end else if (neg) begin
            if (q > 32'h8000_0000) res = {1'b1, 32'h8000_0000};
            else                   res = {1'b0, ~q + WORD_W'(1)};
        end else begin
            if (q > 32'h7FFF_FFFF) res = {1'b1, 32'h7FFF_FFFF};
            else                   res = {1'b0, q};
        end
        return res;
    endfunction

    // stage 1: magnitudes and products
    logic [WORD_W:0] px_s, py_s, vx_s, vy_s;
    logic [WORD_W-1:0] pm1_reg, qm1_reg;
    logic pn1_reg, qn1_reg, an1_reg, bn1_reg;
    logic [R2_W-1:0] pp1_reg, qq1_reg, a1_reg, b1_reg;

    assign px_s = mag(s_tdata[31:0]);
    assign py_s = mag(s_tdata[63:32]);
    assign vx_s = mag(s_tdata[95:64]);
    assign vy_s = mag(s_tdata[127:96]);

    always_ff @(posedge aclk) begin
        if (en) begin
            pm1_reg <= px_s[WORD_W-1:0];
            qm1_reg <= py_s[WORD_W-1:0];
            pn1_reg <= px_s[WORD_W];
            qn1_reg <= py_s[WORD_W];
            an1_reg <= vx_s[WORD_W] ^ py_s[WORD_W];
            bn1_reg <= vy_s[WORD_W] ^ px_s[WORD_W];
            pp1_reg <= {32'b0, px_s[WORD_W-1:0]} * {32'b0, px_s[WORD_W-1:0]};
            qq1_reg <= {32'b0, py_s[WORD_W-1:0]} * {32'b0, py_s[WORD_W-1:0]};
            a1_reg  <= {32'b0, vx_s[WORD_W-1:0]} * {32'b0, py_s[WORD_W-1:0]};
            b1_reg  <= {32'b0, vy_s[WORD_W-1:0]} * {32'b0, px_s[WORD_W-1:0]};
        end
    end

    // stage 2: r squared and cross term vx*py - vy*px
    side_t sd2_next, sd2_reg;

    always_comb begin
        sd2_next.pm   = pm1_reg;
        sd2_next.qm   = qm1_reg;
        sd2_next.pn   = pn1_reg;
        sd2_next.qn   = qn1_reg;
        sd2_next.r2   = pp1_reg + qq1_reg;
        sd2_next.zero = (pm1_reg == '0) && (qm1_reg == '0);
        if (an1_reg != bn1_reg) begin
            sd2_next.cm = a1_reg + b1_reg;
            sd2_next.cn = an1_reg;
        end else if (a1_reg >= b1_reg) begin
            sd2_next.cm = a1_reg - b1_reg;
            sd2_next.cn = an1_reg;
        end else begin
            sd2_next.cm = b1_reg - a1_reg;
            sd2_next.cn = !an1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) sd2_reg <= sd2_next;
    end

    // square root with side data delayed alongside
    logic [WORD_W-1:0] r_s;
    side_t sq_side_reg [0:SQRT_STAGES-1];

    jac_sqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .n    (sd2_reg.r2),
        .root (r_s)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_side_reg[0] <= sd2_reg;
            for (int i = 1; i < SQRT_STAGES; i++) sq_side_reg[i] <= sq_side_reg[i-1];
        end
    end

    side_t sq_out;
    assign sq_out = sq_side_reg[SQRT_STAGES-1];

    // partial products for r^3, py*c and px*c
    logic [R2_W-1:0] r2lr_reg, r2hr_reg, qcl_reg, qch_reg, pcl_reg, pch_reg;
    logic [WORD_W-1:0] rm1_reg;
    side_t sm1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            r2lr_reg <= {32'b0, sq_out.r2[31:0]}  * {32'b0, r_s};
            r2hr_reg <= {32'b0, sq_out.r2[63:32]} * {32'b0, r_s};
            qcl_reg  <= {32'b0, sq_out.qm} * {32'b0, sq_out.cm[31:0]};
            qch_reg  <= {32'b0, sq_out.qm} * {32'b0, sq_out.cm[63:32]};
            pcl_reg  <= {32'b0, sq_out.pm} * {32'b0, sq_out.cm[31:0]};
            pch_reg  <= {32'b0, sq_out.pm} * {32'b0, sq_out.cm[63:32]};
            rm1_reg  <= r_s;
            sm1_reg  <= sq_out;
        end
    end

    logic [R3_W-1:0] r3_reg, qc_reg, pc_reg;
    logic [WORD_W-1:0] rm2_reg;
    side_t sm2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            r3_reg  <= {r2hr_reg, 32'b0} + {32'b0, r2lr_reg};
            qc_reg  <= {qch_reg, 32'b0} + {32'b0, qcl_reg};
            pc_reg  <= {pch_reg, 32'b0} + {32'b0, pcl_reg};
            rm2_reg <= rm1_reg;
            sm2_reg <= sm1_reg;
        end
    end

    // six dividers
    logic [QUO_W-1:0] quo [0:5];
    logic [5:0]       ovf;

    jac_div #(.NUM_W(NW_RG), .DEN_W(WORD_W)) u_div_rx (
        .aclk(aclk), .en(en), .num({sm2_reg.pm, {FRAC_BITS{1'b0}}}), .den(rm2_reg),
        .quo(quo[0]), .ovf(ovf[0]));
    jac_div #(.NUM_W(NW_RG), .DEN_W(WORD_W)) u_div_ry (
        .aclk(aclk), .en(en), .num({sm2_reg.qm, {FRAC_BITS{1'b0}}}), .den(rm2_reg),
        .quo(quo[1]), .ovf(ovf[1]));
    jac_div #(.NUM_W(NW_BR), .DEN_W(R2_W)) u_div_bx (
        .aclk(aclk), .en(en), .num({sm2_reg.qm, {(2*FRAC_BITS){1'b0}}}), .den(sm2_reg.r2),
        .quo(quo[2]), .ovf(ovf[2]));
    jac_div #(.NUM_W(NW_BR), .DEN_W(R2_W)) u_div_by (
        .aclk(aclk), .en(en), .num({sm2_reg.pm, {(2*FRAC_BITS){1'b0}}}), .den(sm2_reg.r2),
        .quo(quo[3]), .ovf(ovf[3]));
    jac_div #(.NUM_W(NW_RT), .DEN_W(R3_W)) u_div_tx (
        .aclk(aclk), .en(en), .num({qc_reg, {FRAC_BITS{1'b0}}}), .den(r3_reg),
        .quo(quo[4]), .ovf(ovf[4]));
    jac_div #(.NUM_W(NW_RT), .DEN_W(R3_W)) u_div_ty (
        .aclk(aclk), .en(en), .num({pc_reg, {FRAC_BITS{1'b0}}}), .den(r3_reg),
        .quo(quo[5]), .ovf(ovf[5]));

    dside_t dv_side_reg [0:DIV_STAGES-1];
    dside_t dside_in;

    always_comb begin
        dside_in.neg  = {sm2_reg.pn ^ !sm2_reg.cn, sm2_reg.qn ^ sm2_reg.cn,
                         sm2_reg.pn, !sm2_reg.qn, sm2_reg.qn, sm2_reg.pn};
        dside_in.zero = sm2_reg.zero;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_side_reg[0] <= dside_in;
            for (int i = 1; i < DIV_STAGES; i++) dv_side_reg[i] <= dv_side_reg[i-1];
        end
    end

    // output stage
    dside_t dout;
    logic [WORD_W:0] cl [0:5];
    logic [191:0] m_tdata_next;
    logic [1:0]   m_tuser_next;
    logic [5:0]   sat_s;

    assign dout = dv_side_reg[DIV_STAGES-1];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            cl[i]    = clamp(quo[i], ovf[i], dout.neg[i]);
            sat_s[i] = cl[i][WORD_W];
        end
        m_tdata_next = {cl[5][WORD_W-1:0], cl[4][WORD_W-1:0], cl[3][WORD_W-1:0],
                        cl[2][WORD_W-1:0], cl[1][WORD_W-1:0], cl[0][WORD_W-1:0]};
        m_tuser_next = {|sat_s, 1'b0};
        if (dout.zero) begin
            m_tdata_next = '0;
            m_tuser_next = 2'b01;
        end
    end

    logic         m_tvalid_reg;
    logic [191:0] m_tdata_reg;
    logic [1:0]   m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[VLEN-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[VLEN-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_zero_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
        else $error("zero range item carries data or saturation");

    a_sat_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |->
            m_tdata[31:0] == 32'h7FFF_FFFF || m_tdata[31:0] == 32'h8000_0000 ||
            m_tdata[63:32] == 32'h7FFF_FFFF || m_tdata[63:32] == 32'h8000_0000 ||
            m_tdata[95:64] == 32'h7FFF_FFFF || m_tdata[95:64] == 32'h8000_0000 ||
            m_tdata[127:96] == 32'h7FFF_FFFF || m_tdata[127:96] == 32'h8000_0000 ||
            m_tdata[159:128] == 32'h7FFF_FFFF || m_tdata[159:128] == 32'h8000_0000 ||
            m_tdata[191:160] == 32'h7FFF_FFFF || m_tdata[191:160] == 32'h8000_0000)
        else $error("saturated flag without a clamped field");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

endmodule

// ----- test/radar_measurement_jacobian_checker.sv -----
// Checker for the radar Jacobian: predicts each accepted state and compares the partials and flags.
module radar_measurement_jacobian_checker
    import jac_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,   // pos_x, pos_y, vel_x, vel_y
    input  logic         m_tvalid,
    input  logic         m_tready,
    // d_range_dpx, d_range_dpy, d_bearing_dpx, d_bearing_dpy, d_rate_dpx, d_rate_dpy
    input  logic [191:0] m_tdata,
    input  logic [1:0]   m_tuser,   // zero_range, saturated
    output int           errors,
    output int           pending
);

    typedef struct {
        logic [191:0] partials;
        logic [1:0]   flags;
    } jacobian_t;

    jacobian_t jacobian_q[$];

    function automatic logic [127:0] magnitude(input logic [31:0] v, output bit neg);
        neg = v[31];
        return neg ? (128'h1_0000_0000 - {96'd0, v}) : {96'd0, v};
    endfunction

    function automatic logic [127:0] floor_sqrt(input logic [127:0] n);
        logic [127:0] root;
        logic [127:0] trial;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (128'd1 << i);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    function automatic logic [31:0] clamp_q16(input logic [127:0] q, input bit neg,
                                              inout bit sat);
        logic [127:0] neg_q;
        if (q == 0)
            return 32'd0;
        if (neg) begin
            if (q > 128'h8000_0000) begin
                sat = 1;
                return 32'h8000_0000;
            end
            neg_q = -q;
            return neg_q[31:0];
        end
        if (q > 128'h7FFF_FFFF) begin
            sat = 1;
            return 32'h7FFF_FFFF;
        end
        return q[31:0];
    endfunction

    function automatic jacobian_t predict_jacobian(input logic [127:0] state);
        jacobian_t    res;
        bit           pn, qn, vxn, vyn, an, bn, cn, sat;
        logic [127:0] pm, qm, vxm, vym, r2, r, r3, a, b, cm;
        pm  = magnitude(state[31:0], pn);
        qm  = magnitude(state[63:32], qn);
        vxm = magnitude(state[95:64], vxn);
        vym = magnitude(state[127:96], vyn);
        r2  = pm * pm + qm * qm;
        res.partials = '0;
        res.flags    = 2'b00;
        sat = 0;
        if (r2 == 0) begin
            res.flags[0] = 1'b1;
            return res;
        end
        r  = floor_sqrt(r2);
        r3 = r2 * r;
        res.partials[31:0]   = clamp_q16((pm << FRAC_BITS_DEF) / r, pn, sat);
        res.partials[63:32]  = clamp_q16((qm << FRAC_BITS_DEF) / r, qn, sat);
        res.partials[95:64]  = clamp_q16((qm << (2 * FRAC_BITS_DEF)) / r2, !qn, sat);
        res.partials[127:96] = clamp_q16((pm << (2 * FRAC_BITS_DEF)) / r2, pn, sat);
        // cross term vx*py - vy*px in sign/magnitude
        a  = vxm * qm;
        an = vxn ^ qn;
        b  = vym * pm;
        bn = vyn ^ pn;
        if (an != bn) begin
            cm = a + b;
            cn = an;
        end else if (a >= b) begin
            cm = a - b;
            cn = an;
        end else begin
            cm = b - a;
            cn = !an;
        end
        res.partials[159:128] = clamp_q16(((qm * cm) << FRAC_BITS_DEF) / r3, qn != cn, sat);
        res.partials[191:160] = clamp_q16(((pm * cm) << FRAC_BITS_DEF) / r3, pn == cn, sat);
        res.flags[1] = sat;
        return res;
    endfunction

    assign pending = jacobian_q.size();

    always @(posedge aclk) begin
        jacobian_t want;
        if (!aresetn) begin
            errors = 0;
            jacobian_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (jacobian_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected item: data=%h user=%b", m_tdata, m_tuser);
                end else begin
                    want = jacobian_q.pop_front();
                    for (int f = 0; f < 6; f++) begin
                        if (m_tdata[32*f +: 32] !== want.partials[32*f +: 32]) begin
                            errors++;
                            if (errors <= 10)
                                $display("partial %0d: expected %h got %h", f,
                                         want.partials[32*f +: 32], m_tdata[32*f +: 32]);
                        end
                    end
                    if (m_tuser !== want.flags) begin
                        errors++;
                        if (errors <= 10)
                            $display("flags (sat,zero): expected %b got %b",
                                     want.flags, m_tuser);
                    end
                end
            end
            if (s_tvalid && s_tready)
                jacobian_q.push_back(predict_jacobian(s_tdata));
        end
    end

endmodule

// ----- test/tb.sv -----
// Testbench top: drives state items into the Jacobian block and reports the verdict.
module tb;
    import jac_pkg::*;

    localparam int LIMIT = 400000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;
    logic [1:0]   m_tuser;
    int           errors;
    int           pending;
    int           cycles = 0;
    bit           hold_off;

    radar_measurement_jacobian uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    radar_measurement_jacobian_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .errors(errors), .pending(pending)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("radar_measurement_jacobian verification failed");
            $finish;
        end
    end

    // receiver: stall pattern mode is redrawn at random, one long hold-off on request
    always @(posedge aclk) begin
        int mode;
        int hold;
        if (!aresetn) begin
            m_tready <= 1'b0;
            mode = 0;
            hold = 0;
        end else begin
            if (cycles % 150 == 0)
                mode = $urandom_range(0, 3);
            if (hold_off && hold == 0)
                hold = 500;
            if (hold > 1) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                if (hold == 1 && !hold_off)
                    hold = 0;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    function automatic logic [31:0] rand_word();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0:       v = $urandom;
            1:       v = $urandom >> $urandom_range(1, 31);
            2:       v = -($urandom >> $urandom_range(1, 31));
            default: v = $urandom >> $urandom_range(12, 31);
        endcase
        if ($urandom_range(0, 15) == 0)
            v = '0;
        return v;
    endfunction

    task automatic send_state(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] vx, input logic [31:0] vy);
        s_tvalid <= 1'b1;
        s_tdata  <= {vy, vx, py, px};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic random_gap();
        int gap;
        gap = $urandom_range(0, 6) == 0 ? $urandom_range(1, 12) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    initial begin
        logic [31:0] edge_vals[8];
        edge_vals = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000};
        hold_off  = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero range, tiny ranges that saturate, extremes on every field
        send_state(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_state(32'h1, 32'h0, 32'h0, 32'h0);
        send_state(32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0);
        send_state(32'h1, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000);
        send_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_state(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_state(32'h8000_0000, 32'h0, 32'h0, 32'h7FFF_FFFF);
        send_state(32'h0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1);
        send_state(32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'hFFFF_0000);
        send_state(32'hFFFD_0000, 32'h0004_0000, 32'h0, 32'h0002_0000);
        for (int i = 0; i < 8; i++)
            send_state(edge_vals[i], edge_vals[7 - i], edge_vals[(i + 3) % 8],
                       edge_vals[(i + 5) % 8]);

        for (int n = 0; n < 600; n++) begin
            if (n == 150)
                hold_off = 1;
            if (n == 250)
                hold_off = 0;
            if (n == 400) begin
                s_tvalid <= 1'b0;
                while (pending != 0) @(posedge aclk);
            end
            send_state(rand_word(), rand_word(), rand_word(), rand_word());
            if (!hold_off)
                random_gap();
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("radar_measurement_jacobian verification clean");
        end else begin
            $display("radar_measurement_jacobian verification failed");
        end
        $finish;
    end

endmodule
